// ===== rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// types and constants shared by the bipartite graph checker
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    localparam logic [1:0] SIDE_A    = 2'd0;
    localparam logic [1:0] SIDE_B    = 2'd1;
    localparam logic [1:0] SIDE_NONE = 2'd2;

    localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;
    localparam logic [6:0] VERTEX_COUNT_RST = 7'd64;

    typedef struct packed {
        logic [5:0] end_a;
        logic [5:0] end_b;
        logic       has_edge;
        logic       last_edge;
    } edge_item_t;

    typedef struct packed {
        logic [5:0] vertex;
        logic [1:0] side;
        logic       not_bipartite;
        logic [6:0] count_side_a;
        logic [6:0] count_side_b;
        logic       input_error;
        logic       last;
    } result_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_EDGE,
        ST_SCAN_CHECK,
        ST_POP,
        ST_POP_WAIT,
        ST_EDGE,
        ST_EDGE_CHECK,
        ST_EMIT_ODD,
        ST_EMIT,
        ST_EMIT_WAIT,
        ST_CLEAR
    } state_t;

endpackage

// ===== rtl/bipartite_graph_checker.sv =====
// ----------------------------------------------------------------------------
// bipartite_graph_checker
// loads an edge list, then two-colors the graph by depth-first walk and
// reports each vertex's side or a single not-bipartite record
// ----------------------------------------------------------------------------
// channel | direction | handshake       | payload
// edge    | in        | valid / ready   | edge_item_t
// result  | out       | valid / ready   | result_item_t
// config  | in        | apb write/read  | vertex_count at address 0
//
// loading takes one edge transfer per cycle into the edge memory
// coloring: an edge scan per start vertex, and per popped vertex a pass over
// every edge, with a neighbor check for each edge that touches it
// output: one record at a time read through the side memory, a stalled record
// holds the block, then a clearing pass over all MAX_VERTICES entries; no input meanwhile
// reset leaves the side memory uncolored through the same clearing pass
// ----------------------------------------------------------------------------
module bipartite_graph_checker
    import bgc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  edge_item_t   in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output result_item_t out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);

    logic [6:0] vcount_reg;
    logic [6:0] n_eff;

    logic [11:0]    edge_mem [MAX_EDGES];
    logic [11:0]    edge_rd_reg;
    logic           edge_we;
    logic [EAW-1:0] edge_ra;

    logic [1:0]     side_mem [MAX_VERTICES];
    logic [1:0]     side_rd_reg;
    logic           side_we;
    logic [VAW-1:0] side_wa;
    logic [1:0]     side_wd;
    logic [VAW-1:0] side_ra;

    logic [5:0]     stack_mem [MAX_VERTICES];
    logic [5:0]     stack_rd_reg;
    logic           stack_we;
    logic [VAW-1:0] stack_wa;
    logic [5:0]     stack_wd;

    state_t state_reg, state_next;
    logic [ETW-1:0] etotal_reg, etotal_next;
    logic [ETW-1:0] eidx_reg, eidx_next;
    logic [VCW-1:0] sdepth_reg, sdepth_next;
    logic [6:0] vidx_reg, vidx_next;
    logic [5:0] now_reg, now_next;
    logic [1:0] want_reg, want_next;
    logic [5:0] nb_reg, nb_next;
    logic [6:0] tally_a_reg, tally_a_next;
    logic [6:0] tally_b_reg, tally_b_next;
    logic drop_reg, drop_next;
    logic touch_reg, touch_next;

    logic [5:0] ea, eb;
    logic       in_range;
    logic       give;
    logic [5:0] give_v;
    logic [1:0] give_s;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, vcount_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= VERTEX_COUNT_RST;
        else if (psel && penable && pwrite && paddr == {REG_VERTEX_COUNT[0], 2'b00})
            vcount_reg <= pwdata[6:0];
    end

    always_comb
    begin
        if (vcount_reg == 7'd0)
            n_eff = 7'd1;
        else if (vcount_reg > 7'(MAX_VERTICES))
            n_eff = 7'(MAX_VERTICES);
        else
            n_eff = vcount_reg;
    end

    assign ea = edge_rd_reg[11:6];
    assign eb = edge_rd_reg[5:0];
    assign in_range = (7'(in_data.end_a) < n_eff) && (7'(in_data.end_b) < n_eff);

    // memories
    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[etotal_reg[EAW-1:0]] <= {in_data.end_a, in_data.end_b};
        edge_rd_reg <= edge_mem[edge_ra];
        if (side_we)
            side_mem[side_wa] <= side_wd;
        side_rd_reg <= side_mem[side_ra];
        if (stack_we)
            stack_mem[stack_wa] <= stack_wd;
        stack_rd_reg <= stack_mem[sdepth_reg[VAW-1:0] - VAW'(1)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            etotal_reg  <= '0;
            eidx_reg    <= '0;
            sdepth_reg  <= '0;
            vidx_reg    <= '0;
            now_reg     <= '0;
            want_reg    <= SIDE_A;
            nb_reg      <= '0;
            tally_a_reg <= '0;
            tally_b_reg <= '0;
            drop_reg    <= 1'b0;
            touch_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            etotal_reg  <= etotal_next;
            eidx_reg    <= eidx_next;
            sdepth_reg  <= sdepth_next;
            vidx_reg    <= vidx_next;
            now_reg     <= now_next;
            want_reg    <= want_next;
            nb_reg      <= nb_next;
            tally_a_reg <= tally_a_next;
            tally_b_reg <= tally_b_next;
            drop_reg    <= drop_next;
            touch_reg   <= touch_next;
        end
    end

    // give a side: write memory, count, push
    assign stack_we = give && (sdepth_reg < VCW'(MAX_VERTICES));
    assign stack_wa = sdepth_reg[VAW-1:0];
    assign stack_wd = give_v;

    always_comb
    begin
        state_next   = state_reg;
        etotal_next  = etotal_reg;
        eidx_next    = eidx_reg;
        sdepth_next  = sdepth_reg;
        vidx_next    = vidx_reg;
        now_next     = now_reg;
        want_next    = want_reg;
        nb_next      = nb_reg;
        tally_a_next = tally_a_reg;
        tally_b_next = tally_b_reg;
        drop_next    = drop_reg;
        touch_next   = touch_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        out_data     = '0;
        edge_we      = 1'b0;
        edge_ra      = eidx_reg[EAW-1:0];
        side_we      = 1'b0;
        side_wa      = vidx_reg[VAW-1:0];
        side_wd      = SIDE_NONE;
        side_ra      = vidx_reg[VAW-1:0];
        give         = 1'b0;
        give_v       = vidx_reg[5:0];
        give_s       = SIDE_A;

        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.has_edge)
                    begin
                        if (etotal_reg < ETW'(MAX_EDGES) && in_range)
                        begin
                            edge_we     = 1'b1;
                            etotal_next = etotal_reg + ETW'(1);
                        end
                        else
                            drop_next = 1'b1;
                    end
                    if (in_data.last_edge)
                    begin
                        vidx_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // side_rd_reg valid next cycle for vidx
                if (vidx_reg >= n_eff)
                begin
                    vidx_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    eidx_next  = '0;
                    touch_next = 1'b0;
                    state_next = ST_SCAN_EDGE;
                end
            end
            ST_SCAN_EDGE:
            begin
                if (side_rd_reg != SIDE_NONE || eidx_reg >= etotal_reg)
                begin
                    if (side_rd_reg == SIDE_NONE && touch_reg)
                    begin
                        give       = 1'b1;
                        give_v     = vidx_reg[5:0];
                        give_s     = SIDE_A;
                        touch_next = 1'b0;
                        state_next = ST_POP;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 7'd1;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    edge_ra    = eidx_reg[EAW-1:0];
                    eidx_next  = eidx_reg + ETW'(1);
                    state_next = ST_SCAN_CHECK;
                end
            end
            ST_SCAN_CHECK:
            begin
                if (ea == vidx_reg[5:0] || eb == vidx_reg[5:0])
                begin
                    touch_next = 1'b1;
                    eidx_next  = etotal_reg;
                end
                state_next = ST_SCAN_EDGE;
            end
            ST_POP:
            begin
                if (sdepth_reg == '0)
                begin
                    vidx_next  = vidx_reg + 7'd1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    sdepth_next = sdepth_reg - VCW'(1);
                    state_next  = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                now_next   = stack_rd_reg;
                side_ra    = stack_rd_reg[VAW-1:0];
                eidx_next  = '0;
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (eidx_reg == ETW'(0) && state_reg == ST_EDGE)
                    want_next = (side_rd_reg == SIDE_A) ? SIDE_B : SIDE_A;
                if (eidx_reg >= etotal_reg)
                    state_next = ST_POP;
                else
                begin
                    edge_ra    = eidx_reg[EAW-1:0];
                    eidx_next  = eidx_reg + ETW'(1);
                    state_next = ST_EDGE_CHECK;
                end
            end
            ST_EDGE_CHECK:
            begin
                // look up the neighbor, result next cycle
                if (ea == now_reg)
                begin
                    nb_next = eb;
                    side_ra = eb[VAW-1:0];
                    state_next = ST_SCAN_CHECK;
                end
                else if (eb == now_reg)
                begin
                    nb_next = ea;
                    side_ra = ea[VAW-1:0];
                    state_next = ST_SCAN_CHECK;
                end
                else
                    state_next = ST_EDGE;
                if (state_next == ST_SCAN_CHECK)
                    state_next = ST_EMIT_ODD;
            end
            ST_EMIT_ODD:
            begin
                // neighbor side is in side_rd_reg
                if (touch_reg)
                begin
                    out_valid = 1'b1;
                    out_data.not_bipartite = 1'b1;
                    out_data.input_error   = drop_reg;
                    out_data.last          = 1'b1;
                    if (out_ready)
                    begin
                        vidx_next  = '0;
                        state_next = ST_CLEAR;
                    end
                end
                else if (side_rd_reg != SIDE_NONE)
                begin
                    if (side_rd_reg != want_reg)
                        touch_next = 1'b1;
                    else
                        state_next = ST_EDGE;
                end
                else
                begin
                    give       = 1'b1;
                    give_v     = nb_reg;
                    give_s     = want_reg;
                    state_next = ST_EDGE;
                end
            end
            ST_EMIT:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                out_valid             = 1'b1;
                out_data.vertex       = vidx_reg[5:0];
                out_data.side         = side_rd_reg;
                out_data.count_side_a = tally_a_reg;
                out_data.count_side_b = tally_b_reg;
                out_data.input_error  = drop_reg;
                out_data.last         = (vidx_reg + 7'd1 == n_eff);
                if (out_ready)
                begin
                    vidx_next = vidx_reg + 7'd1;
                    if (vidx_reg + 7'd1 == n_eff)
                    begin
                        vidx_next  = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_CLEAR:
            begin
                side_we = 1'b1;
                side_wa = vidx_reg[VAW-1:0];
                side_wd = SIDE_NONE;
                vidx_next = vidx_reg + 7'd1;
                if (vidx_reg == 7'(MAX_VERTICES - 1))
                begin
                    vidx_next    = '0;
                    etotal_next  = '0;
                    sdepth_next  = '0;
                    tally_a_next = '0;
                    tally_b_next = '0;
                    drop_next    = 1'b0;
                    touch_next   = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (give)
        begin
            side_we = 1'b1;
            side_wa = give_v[VAW-1:0];
            side_wd = give_s;
            if (give_s == SIDE_A)
                tally_a_next = tally_a_reg + 7'd1;
            else
                tally_b_next = tally_b_reg + 7'd1;
            if (sdepth_reg < VCW'(MAX_VERTICES))
                sdepth_next = sdepth_reg + VCW'(1);
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for bipartite_graph_checker: streams directed and random
// edge lists through the edge channel and predicts every result record (side
// per vertex, side counts, drop flag, odd-cycle record). vertex_count is
// changed over the apb port between graphs. handshakes idle and stall at
// random, and one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import bgc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 2 * DEF_MAX_VERTICES + 40;

    class coloring_board;
        logic [11:0]  edge_mem [DEF_MAX_EDGES];
        int unsigned  edge_cnt;
        logic [1:0]   side_of [64];
        logic [5:0]   stack [64];
        int unsigned  depth;
        int unsigned  tally_a;
        int unsigned  tally_b;
        bit           dropped;
        logic [6:0]   vcount;
        result_item_t expected_records [$];
        int           errors;
        int           records_seen;
        int           graphs_done;
        int           odd_graphs;

        function new();
            vcount = VERTEX_COUNT_RST;
            errors = 0;
            records_seen = 0;
            graphs_done = 0;
            odd_graphs = 0;
            clear_graph();
        endfunction

        function void clear_graph();
            edge_cnt = 0;
            for (int i = 0; i < 64; i++)
                side_of[i] = SIDE_NONE;
            depth = 0;
            tally_a = 0;
            tally_b = 0;
            dropped = 0;
        endfunction

        function int unsigned eff_count();
            if (vcount == 0)
                return 1;
            if (vcount > DEF_MAX_VERTICES)
                return DEF_MAX_VERTICES;
            return vcount;
        endfunction

        function bit touches(int unsigned v);
            for (int unsigned e = 0; e < edge_cnt; e++)
                if (edge_mem[e][11:6] == v || edge_mem[e][5:0] == v)
                    return 1;
            return 0;
        endfunction

        function void color(int unsigned v, logic [1:0] s);
            side_of[v] = s;
            if (s == SIDE_A)
                tally_a++;
            else
                tally_b++;
            if (depth < 64)
            begin
                stack[depth] = 6'(v);
                depth++;
            end
        endfunction

        function bit walk(int unsigned start);
            int unsigned cur;
            int unsigned nb;
            logic [1:0]  want;
            color(start, SIDE_A);
            while (depth > 0)
            begin
                depth--;
                cur = stack[depth];
                for (int unsigned e = 0; e < edge_cnt; e++)
                begin
                    want = (side_of[cur] == SIDE_A) ? SIDE_B : SIDE_A;
                    if (edge_mem[e][11:6] == cur)
                        nb = edge_mem[e][5:0];
                    else if (edge_mem[e][5:0] == cur)
                        nb = edge_mem[e][11:6];
                    else
                        continue;
                    if (side_of[nb] != SIDE_NONE)
                    begin
                        if (side_of[nb] != want)
                            return 1;
                    end
                    else
                        color(nb, want);
                end
            end
            return 0;
        endfunction

        function void note_edge(edge_item_t it);
            int unsigned  n;
            bit           odd;
            result_item_t r;
            n = eff_count();
            odd = 0;
            if (it.has_edge)
            begin
                if (edge_cnt < DEF_MAX_EDGES && it.end_a < n && it.end_b < n)
                begin
                    edge_mem[edge_cnt] = {it.end_a, it.end_b};
                    edge_cnt++;
                end
                else
                    dropped = 1;
            end
            if (!it.last_edge)
                return;
            for (int unsigned v = 0; v < n && !odd; v++)
                if (side_of[v] == SIDE_NONE && touches(v))
                    odd = walk(v);
            graphs_done++;
            if (odd)
            begin
                odd_graphs++;
                r = '0;
                r.not_bipartite = 1;
                r.input_error = dropped;
                r.last = 1;
                expected_records = {expected_records, r};
            end
            else
            begin
                for (int unsigned v = 0; v < n; v++)
                begin
                    r = '0;
                    r.vertex = 6'(v);
                    r.side = side_of[v];
                    r.count_side_a = 7'(tally_a);
                    r.count_side_b = 7'(tally_b);
                    r.input_error = dropped;
                    r.last = (v + 1 == n);
                    expected_records = {expected_records, r};
                end
            end
            clear_graph();
        endfunction

        function void check_record(result_item_t got);
            result_item_t want;
            records_seen++;
            if (expected_records.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected record, exp none, got v=%0d s=%0d nb=%0d", $realtime,
                         got.vertex, got.side, got.not_bipartite);
                return;
            end
            want = expected_records.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: record mismatch exp v=%0d s=%0d nb=%0d a=%0d b=%0d err=%0d l=%0d",
                         $realtime, want.vertex, want.side, want.not_bipartite,
                         want.count_side_a, want.count_side_b, want.input_error, want.last);
                $display("%0t:                 got v=%0d s=%0d nb=%0d a=%0d b=%0d err=%0d l=%0d",
                         $realtime, got.vertex, got.side, got.not_bipartite,
                         got.count_side_a, got.count_side_b, got.input_error, got.last);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    edge_item_t   in_data;
    logic         out_valid;
    logic         out_ready;
    result_item_t out_data;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    coloring_board board;
    int            send_idle;
    int            recv_idle;
    int            hold_request;
    int            hold_left;
    int            edges_sent;
    longint        cycles;

    bipartite_graph_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: check transfers, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_record(out_data);
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_edge(logic [5:0] a, logic [5:0] b, bit has, bit fin);
        edge_item_t it;
        it.end_a = a;
        it.end_b = b;
        it.has_edge = has;
        it.last_edge = fin;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            in_data <= edge_item_t'(14'($urandom));
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_edge(it);
        edges_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [6:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_VERTEX_COUNT[0], 2'b00};
        pwdata <= {25'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.vcount = value;
    endtask

    // one graph: bipartite-leaning or random edges, with some noise items
    task automatic send_graph(int n_edges, bit bip, int noise_pct);
        int unsigned n;
        bit          part [64];
        logic [5:0]  a;
        logic [5:0]  b;
        int          tries;
        n = board.eff_count();
        for (int i = 0; i < 64; i++)
            part[i] = $urandom_range(1);
        for (int i = 0; i < n_edges; i++)
        begin
            a = 6'($urandom_range(n - 1));
            b = 6'($urandom_range(n - 1));
            tries = 0;
            while (bip && part[a] == part[b] && tries < 20)
            begin
                b = 6'($urandom_range(n - 1));
                tries++;
            end
            if ($urandom_range(99) < noise_pct)
            begin
                case ($urandom_range(2))
                    0: send_edge(6'($urandom), 6'($urandom), 1'b0, 1'b0);
                    1: send_edge(6'($urandom), 6'($urandom), 1'b1, 1'b0);
                    default: send_edge(a, a, 1'b1, 1'b0);
                endcase
            end
            send_edge(a, b, 1'b1, (i == n_edges - 1) && $urandom_range(1));
        end
        if (board.edge_cnt != 0 || board.dropped)
            send_edge(6'($urandom), 6'($urandom), 1'b0, 1'b1);
    endtask

    task automatic random_phase(int items);
        int start;
        int k;
        logic [6:0] counts [6];
        counts = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'd8};
        start = edges_sent;
        k = 0;
        while (edges_sent - start < items)
        begin
            if ($urandom_range(5) == 0)
            begin
                if ($urandom_range(2) == 0)
                    write_vertex_count(7'($urandom_range(127)));
                else
                    write_vertex_count(counts[k % 6]);
                k++;
            end
            send_graph($urandom_range(1, 14), $urandom_range(99) < 65,
                       $urandom_range(0, 15));
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle = 30;
        recv_idle = 57;
        hold_request = 0;
        hold_left = 0;
        edges_sent = 0;
        cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);

        // directed: extremes, empty graph, self-loop, triangle, range and count edges
        send_edge(6'd0, 6'd63, 1'b1, 1'b1);
        send_edge(6'd63, 6'd0, 1'b0, 1'b1);
        send_edge(6'd5, 6'd5, 1'b1, 1'b1);
        send_edge(6'd1, 6'd2, 1'b1, 1'b0);
        send_edge(6'd2, 6'd3, 1'b1, 1'b0);
        send_edge(6'd3, 6'd1, 1'b1, 1'b1);
        send_edge(6'd10, 6'd11, 1'b1, 1'b0);
        send_edge(6'd42, 6'd21, 1'b1, 1'b0);
        send_edge(6'd11, 6'd12, 1'b1, 1'b1);
        write_vertex_count(7'd10);
        send_edge(6'd12, 6'd3, 1'b1, 1'b0);
        send_edge(6'd9, 6'd0, 1'b1, 1'b1);
        send_edge(6'd1, 6'd9, 1'b1, 1'b0);
        send_edge(6'd9, 6'd10, 1'b1, 1'b1);
        write_vertex_count(7'd0);
        send_edge(6'd0, 6'd1, 1'b1, 1'b1);
        send_edge(6'd0, 6'd0, 1'b1, 1'b1);
        send_edge(6'd0, 6'd0, 1'b0, 1'b1);
        write_vertex_count(7'd127);
        send_edge(6'd63, 6'd62, 1'b1, 1'b1);
        write_vertex_count(7'd1);
        send_edge(6'd0, 6'd0, 1'b0, 1'b1);

        // store overflow on a small vertex set
        write_vertex_count(7'd4);
        for (int i = 0; i < DEF_MAX_EDGES + 2; i++)
            send_edge(6'd0, 6'(1 + $urandom_range(1) * 2), 1'b1, 1'b0);
        send_edge(6'd2, 6'd1, 1'b1, 1'b1);
        write_vertex_count(7'd64);

        random_phase(30);
        hold_request = 400;
        send_graph(10, 1'b1, 0);
        send_graph(10, 1'b1, 0);
        send_graph(6, 1'b0, 0);
        send_idle = 57;
        recv_idle = 30;
        random_phase(45);
        send_idle = 0;
        recv_idle = 0;
        random_phase(45);
        write_vertex_count(7'd64);
        send_graph(12, 1'b1, 5);

        drain();
        $display("covered %0d edge transfers, %0d graphs (%0d odd), %0d records checked",
                 edges_sent, board.graphs_done, board.odd_graphs, board.records_seen);
        if (board.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
